/* src/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* src/cbz_pkg.sv */
package cbz_pkg;

  localparam int CoordW  = 16;
  localparam int PointW  = 3 * CoordW;
  localparam int ParamW  = 17;
  localparam int WeightW = 49;
  localparam int ProdW   = 64;
  localparam int PairW   = 65;
  localparam int SumW    = 66;
  localparam int FracW   = 48;
  localparam int NumPts  = 4;

  localparam logic [ParamW-1:0] TOne      = ParamW'(65536);
  localparam logic [CoordW-1:0] CoordBias = 16'h8000;
  localparam logic [PairW-1:0]  RoundHalf = PairW'(1) << (FracW - 1);

  typedef logic [WeightW-1:0] weight_t;

  // Products of one control point's biased coordinates with its weight.
  typedef struct packed {
    logic [ProdW-1:0] z;
    logic [ProdW-1:0] y;
    logic [ProdW-1:0] x;
  } prod_t;

  typedef struct packed {
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } point_t;

endpackage

/* src/cbz_weights.sv */
module cbz_weights
  import cbz_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ParamW-1:0] t_in,
  output weight_t           w [NumPts]
);

  logic [ParamW-1:0] t1, u1, t2, u2;
  logic [32:0]       uu, tt;

  logic [49:0] uuu, ttt, tuu_raw, ttu_raw;
  logic [50:0] tuu3, ttu3;

  // Stage 1: clamp t to one and form u = 1 - t.
  always_ff @(posedge clk) begin
    if (en) begin
      if (t_in > TOne) begin
        t1 <= TOne;
        u1 <= '0;
      end else begin
        t1 <= t_in;
        u1 <= TOne - t_in;
      end
    end
  end

  // Stage 2: squares.
  always_ff @(posedge clk) begin
    if (en) begin
      uu <= 33'({17'b0, u1} * {17'b0, u1});
      tt <= 33'({17'b0, t1} * {17'b0, t1});
      t2 <= t1;
      u2 <= u1;
    end
  end

  // Stage 3: cubes and the two mixed terms, times three by shift and add.
  always_comb begin
    uuu     = 50'(uu) * 50'(u2);
    ttt     = 50'(tt) * 50'(t2);
    tuu_raw = 50'(uu) * 50'(t2);
    ttu_raw = 50'(tt) * 50'(u2);
    tuu3    = {tuu_raw, 1'b0} + 51'(tuu_raw);
    ttu3    = {ttu_raw, 1'b0} + 51'(ttu_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w[0] <= uuu[WeightW-1:0];
      w[1] <= tuu3[WeightW-1:0];
      w[2] <= ttu3[WeightW-1:0];
      w[3] <= ttt[WeightW-1:0];
    end
  end

endmodule

/* src/cbz_lane.sv */
module cbz_lane
  import cbz_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PointW-1:0] point,
  input  weight_t           weight,
  output prod_t             prod
);

  logic [CoordW-1:0] bx, by, bz;
  logic [64:0]       mx, my, mz;

  // Coordinates are offset by half the range so the products are unsigned.
  always_comb begin
    bx = point[15:0]  ^ CoordBias;
    by = point[31:16] ^ CoordBias;
    bz = point[47:32] ^ CoordBias;
    mx = 65'(bx) * 65'(weight);
    my = 65'(by) * 65'(weight);
    mz = 65'(bz) * 65'(weight);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.x <= mx[ProdW-1:0];
      prod.y <= my[ProdW-1:0];
      prod.z <= mz[ProdW-1:0];
    end
  end

endmodule

/* src/cbz_merge.sv */
module cbz_merge
  import cbz_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  prod_t  prod [NumPts],
  output point_t result
);

  logic [PairW-1:0] ax, ay, az, bx, by, bz;

  // Undo the bias, round at bit 47 and clip to the signed 16-bit range.
  function automatic logic [CoordW-1:0] round_sat(input logic [SumW-1:0] s);
    logic [CoordW-1:0] r;
    if (s[SumW-1:FracW+CoordW] != '0) begin
      r = 16'h7FFF;
    end else begin
      r = s[FracW+CoordW-1:FracW] ^ CoordBias;
    end
    return r;
  endfunction

  // First level: two pair sums per coordinate, rounding constant folded in.
  always_ff @(posedge clk) begin
    if (en) begin
      ax <= 65'(prod[0].x) + 65'(prod[1].x) + RoundHalf;
      ay <= 65'(prod[0].y) + 65'(prod[1].y) + RoundHalf;
      az <= 65'(prod[0].z) + 65'(prod[1].z) + RoundHalf;
      bx <= 65'(prod[2].x) + 65'(prod[3].x);
      by <= 65'(prod[2].y) + 65'(prod[3].y);
      bz <= 65'(prod[2].z) + 65'(prod[3].z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.x <= round_sat(66'(ax) + 66'(bx));
      result.y <= round_sat(66'(ay) + 66'(by));
      result.z <= round_sat(66'(az) + 66'(bz));
    end
  end

endmodule

/* src/cubic_bezier_point_eval.sv */
// Cubic Bezier point evaluator, 3D, fixed point.
// Each request on the slave stream carries four control points and a curve
// parameter t. The block forms the four cubic Bernstein weights and returns
// one request on the master stream with the weighted point x, y and z in
// signed Q8.8, rounded to nearest with ties toward plus infinity.
// A parameter above one is treated as one.
// Throughput is one request per cycle while the skid register is empty. A
// request passes in order through the weight stages, the multiply register of
// the four point lanes, the adder registers that merge the lanes, and the
// output register.
// Reset clears every valid bit in the pipeline, the output register and the
// skid register; data registers keep whatever they held.
// When the receiver stalls, the output register holds its request and one
// more finished result lands in the skid register. While the skid register
// is full the whole pipeline freezes and s_axis_tready is low; it rises again
// in the cycle after the held result is taken. No request is dropped.
module cubic_bezier_point_eval
  import cbz_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_point, first_control, second_control, end_point, curve_param, zeros
  input  logic [215:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_x, point_y, point_z
  output logic [47:0]  m_axis_tdata
);

  localparam int Depth = 6;

  logic              en;
  logic [Depth-1:0]  vld;
  logic [PointW-1:0] pts1 [NumPts];
  logic [PointW-1:0] pts2 [NumPts];
  logic [PointW-1:0] pts3 [NumPts];
  weight_t           w [NumPts];
  prod_t             prod [NumPts];
  point_t            res;
  logic              skid_valid;
  logic [47:0]       skid_data;

  // The pipeline runs whenever the skid register is free.
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_axis_tvalid};
    end
  end

  // Control points ride alongside the weight pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NumPts; i++) begin
        pts1[i] <= s_axis_tdata[i*PointW +: PointW];
        pts2[i] <= pts1[i];
        pts3[i] <= pts2[i];
      end
    end
  end

  cbz_weights u_weights (
    .clk  (clk),
    .en   (en),
    .t_in (s_axis_tdata[NumPts*PointW +: ParamW]),
    .w    (w)
  );

  for (genvar g = 0; g < NumPts; g++) begin : g_lane
    cbz_lane u_lane (
      .clk    (clk),
      .en     (en),
      .point  (pts3[g]),
      .weight (w[g]),
      .prod   (prod[g])
    );
  end

  cbz_merge u_merge (
    .clk    (clk),
    .en     (en),
    .prod   (prod),
    .result (res)
  );

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= skid_data;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= vld[Depth-1];
        m_axis_tdata  <= res;
      end
    end else if (en && vld[Depth-1]) begin
      skid_valid <= 1'b1;
      skid_data  <= res;
    end
  end

endmodule

/* src/cbz_checker.sv */
`include "assert_macros.svh"

module cbz_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  `ASSERT_CLK(a_out_valid_holds, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_CLK(a_out_data_holds, clk, rst,
              m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_axis_tvalid && s_axis_tready)
  `ASSERT_CLK(a_backpressure_cause, clk, rst,
              !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))

endmodule

bind cubic_bezier_point_eval cbz_checker u_checker (.*);
